@@ rtl/core/dcbs_pkg.sv @@
// ----------------------------------------------------------------------------
// dcbs_pkg
// Shared types and constants for the dual codebook bank selector.
// ----------------------------------------------------------------------------
package dcbs_pkg;

  localparam int CbEntries = 16;
  localparam int CbAw      = $clog2(CbEntries);
  localparam int CostW     = 128;
  localparam int CtrW      = 32;
  localparam int ObjW      = 9;
  localparam int ShW       = 11;
  localparam int AmtW      = 7;

  localparam int InDataW   = 64;
  localparam int OutDataW  = 192;
  localparam int OutUserW  = 2;

  // input tdata layout, lowest bit first
  localparam int BankLsb   = 0;
  localparam int SlotLsb   = 1;
  localparam int ValueLsb  = 5;
  localparam int WeightLsb = 13;
  localparam int MantLsb   = 29;
  localparam int ExpLsb    = 45;
  localparam int IdxLsb    = 53;

  localparam logic       ReqEntry   = 1'b0;
  localparam logic       ReqElement = 1'b1;
  localparam logic [7:0] ExpInfNan  = 8'hFF;
  localparam int         QBias      = 38;
  localparam int         LBias      = 19;
  localparam int         NormBias   = 134;
  localparam int         SubnT      = -133;
  localparam int         ShiftLimit = 120;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SHIFT,
    ST_SUM,
    ST_ACC,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic shift;
    logic sum;
    logic acc;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_elem;
    logic in_idx_ok;
    logic in_last;
    logic last_q;
    logic out_busy;
  } status_t;

endpackage

@@ rtl/core/dcbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcbs_ctrl
// Sequencer: steps each element through the multiply, shift, sum and
// accumulate phases, then decides and emits at the end of a block.
// ----------------------------------------------------------------------------
module dcbs_ctrl
  import dcbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid && status.in_elem) begin
          if (status.in_idx_ok) begin
            state_next = ST_MUL1;
          end else if (status.in_last) begin
            state_next = ST_DECIDE;
          end
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.last_q ? ST_DECIDE : ST_IDLE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/dcbs_datapath.sv @@
// ----------------------------------------------------------------------------
// dcbs_datapath
// Codebook banks, error term arithmetic, bank costs, totals and the
// output register.
// ----------------------------------------------------------------------------
module dcbs_datapath
  import dcbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ObjW-1:0]     cfg_wdata,
  input  logic [InDataW-1:0]  s_tdata,
  input  logic                s_tuser,
  input  logic                s_tlast,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [OutDataW-1:0] m_tdata,
  output logic [OutUserW-1:0] m_tuser,
  input  cmd_t                cmd,
  output status_t             status
);

  logic [7:0] mem_a [CbEntries];
  logic [7:0] mem_b [CbEntries];

  logic signed [ObjW-1:0] objective;

  logic              in_bank;
  logic [3:0]        in_slot;
  logic [7:0]        in_value;
  logic [15:0]       in_weight;
  logic [15:0]       in_mant;
  logic [7:0]        in_exp;
  logic [7:0]        in_idx;
  logic [7:0]        w_ex;
  logic [6:0]        w_fr;
  logic [7:0]        sig_mag;
  logic signed [8:0] sig_in;
  logic signed [ShW-1:0] e_x;
  logic signed [ShW-1:0] o_x;
  logic signed [ShW-1:0] t_x;
  logic signed [ShW-1:0] qs;
  logic signed [ShW-1:0] ls;
  logic              zero_w;
  logic              inf_nan;
  logic              qs_ok;
  logic              ls_ok;

  logic signed [7:0]  pa;
  logic signed [7:0]  pb;
  logic signed [8:0]  sig;
  logic [15:0]        mant;
  logic [AmtW-1:0]    qs_amt;
  logic [AmtW-1:0]    ls_amt;
  logic               quad_en;
  logic               lin_en;
  logic               last_q;

  logic signed [15:0] sq_a_w;
  logic signed [15:0] sq_b_w;
  logic signed [16:0] ps_a_w;
  logic signed [16:0] ps_b_w;
  logic [14:0]        pp_a;
  logic [14:0]        pp_b;
  logic [31:0]        mm;
  logic signed [16:0] ps_a;
  logic signed [16:0] ps_b;
  logic [46:0]        quad_a;
  logic [46:0]        quad_b;
  logic signed [33:0] lin_a;
  logic signed [33:0] lin_b;
  logic signed [34:0] nlin_a;
  logic signed [34:0] nlin_b;
  logic [CostW-1:0]   shl_lin_a;
  logic [CostW-1:0]   shl_lin_b;
  logic [CostW-1:0]   shl_quad_a;
  logic [CostW-1:0]   shl_quad_b;
  logic [CostW-1:0]   term_a;
  logic [CostW-1:0]   term_b;
  logic [CostW-1:0]   cost_a;
  logic [CostW-1:0]   cost_b;
  logic               sel_b;
  logic               tied;
  logic [CtrW-1:0]    b_total;
  logic [CtrW-1:0]    t_total;
  logic [CtrW-1:0]    b_total_next;
  logic [CtrW-1:0]    t_total_next;
  logic [CostW-1:0]   chosen;

  assign in_bank   = s_tdata[BankLsb];
  assign in_slot   = s_tdata[SlotLsb +: 4];
  assign in_value  = s_tdata[ValueLsb +: 8];
  assign in_weight = s_tdata[WeightLsb +: 16];
  assign in_mant   = s_tdata[MantLsb +: 16];
  assign in_exp    = s_tdata[ExpLsb +: 8];
  assign in_idx    = s_tdata[IdxLsb +: 8];

  assign status.in_elem   = (s_tuser == ReqElement);
  assign status.in_idx_ok = ({1'b0, in_idx} < 9'(CbEntries));
  assign status.in_last   = s_tlast;
  assign status.last_q    = last_q;
  assign status.out_busy  = m_tvalid && !m_tready;

  // decode the weight and work out both shift amounts
  always_comb begin
    w_ex    = in_weight[14:7];
    w_fr    = in_weight[6:0];
    zero_w  = (in_weight[14:0] == 15'd0);
    inf_nan = (w_ex == ExpInfNan);
    sig_mag = (w_ex == 8'd0) ? {1'b0, w_fr} : {1'b1, w_fr};
    sig_in  = in_weight[15] ? -$signed({1'b0, sig_mag}) : $signed({1'b0, sig_mag});
    e_x     = {{(ShW-8){in_exp[7]}}, in_exp};
    o_x     = {{(ShW-ObjW){objective[ObjW-1]}}, objective};
    t_x     = (w_ex == 8'd0) ? ShW'(SubnT)
                             : $signed({{(ShW-8){1'b0}}, w_ex}) - ShW'(NormBias);
    qs      = (e_x <<< 1) - ShW'(QBias) - o_x;
    ls      = t_x + e_x - ShW'(LBias) - o_x;
    qs_ok   = (qs >= 0) && (qs < ShW'(ShiftLimit));
    ls_ok   = (ls >= 0) && (ls < ShW'(ShiftLimit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      objective <= '0;
    end else if (cfg_we) begin
      objective <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && s_tuser == ReqEntry && {1'b0, in_slot} < 5'(CbEntries)) begin
      if (in_bank) begin
        mem_b[in_slot[CbAw-1:0]] <= in_value;
      end else begin
        mem_a[in_slot[CbAw-1:0]] <= in_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pa      <= mem_a[in_idx[CbAw-1:0]];
      pb      <= mem_b[in_idx[CbAw-1:0]];
      sig     <= sig_in;
      mant    <= in_mant;
      qs_amt  <= qs[AmtW-1:0];
      ls_amt  <= ls[AmtW-1:0];
      quad_en <= !inf_nan && qs_ok && (zero_w || ls_ok);
      lin_en  <= !inf_nan && !zero_w && qs_ok && ls_ok;
      last_q  <= s_tlast;
    end
  end

  always_comb begin
    sq_a_w = pa * pa;
    sq_b_w = pb * pb;
    ps_a_w = pa * sig;
    ps_b_w = pb * sig;
    nlin_a = -$signed({lin_a, 1'b0});
    nlin_b = -$signed({lin_b, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      pp_a <= sq_a_w[14:0];
      pp_b <= sq_b_w[14:0];
      mm   <= mant * mant;
      ps_a <= ps_a_w;
      ps_b <= ps_b_w;
    end
    if (cmd.mul2) begin
      quad_a <= pp_a * mm;
      quad_b <= pp_b * mm;
      lin_a  <= ps_a * $signed({1'b0, mant});
      lin_b  <= ps_b * $signed({1'b0, mant});
    end
    if (cmd.shift) begin
      shl_lin_a  <= lin_en ? {{(CostW-35){nlin_a[34]}}, nlin_a} << ls_amt : '0;
      shl_lin_b  <= lin_en ? {{(CostW-35){nlin_b[34]}}, nlin_b} << ls_amt : '0;
      shl_quad_a <= quad_en ? {{(CostW-47){1'b0}}, quad_a} << qs_amt : '0;
      shl_quad_b <= quad_en ? {{(CostW-47){1'b0}}, quad_b} << qs_amt : '0;
    end
    if (cmd.sum) begin
      term_a <= shl_lin_a + shl_quad_a;
      term_b <= shl_lin_b + shl_quad_b;
    end
    if (cmd.decide) begin
      sel_b <= $signed(cost_b) < $signed(cost_a);
      tied  <= (cost_a == cost_b);
    end
  end

  assign chosen       = sel_b ? cost_b : cost_a;
  assign b_total_next = b_total + CtrW'(sel_b);
  assign t_total_next = t_total + CtrW'(tied);

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_a   <= '0;
      cost_b   <= '0;
      b_total  <= '0;
      t_total  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        cost_a   <= '0;
        cost_b   <= '0;
        b_total  <= b_total_next;
        t_total  <= t_total_next;
        m_tvalid <= 1'b1;
      end else begin
        if (cmd.acc) begin
          cost_a <= cost_a + term_a;
          cost_b <= cost_b + term_b;
        end
        if (m_tready) begin
          m_tvalid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {t_total_next[31:0], b_total_next[31:0], chosen};
      m_tuser <= {tied, sel_b};
    end
  end

endmodule

@@ rtl/core/dual_codebook_bank_select.sv @@
// ----------------------------------------------------------------------------
// dual_codebook_bank_select
// Per-block choice between two codebook banks by exact squared error.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser 0 loads a codepoint into bank A or B, 1 is a
// weight element; s_tlast marks the last element of a block. Output stream
// m_*: one item per block, giving the cheaper bank, its 128-bit cost, a tie
// flag and running totals. cfg_we/cfg_wdata set the objective exponent.
// A codepoint load is written as it is taken. An element with a valid code
// index passes through capture with the bank read, two multiply stages,
// the 128-bit shift, the term sum and the cost add, in that order on the
// shared sequencer. An element with index 16 or more is skipped and adds
// no cost. On a last element the sequencer then compares the costs and
// loads the output register. Items are taken one at a time.
// The output register holds a finished item while the next ones are taken;
// if it is still full at the end of the next block, the sequencer waits.
// Reset clears the costs, totals, objective exponent and output valid;
// codebook contents are undefined until loaded.
// ----------------------------------------------------------------------------
module dual_codebook_bank_select
  import dcbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ObjW-1:0]     cfg_wdata,      // cost shift exponent
  input  logic                s_tvalid,
  output logic                s_tready,
  // entry_bank, entry_slot, entry_value, weight_bits, scale_mantissa,
  // scale_exp, code_index, zero pad
  input  logic [InDataW-1:0]  s_tdata,
  input  logic                s_tuser,        // req_type
  input  logic                s_tlast,        // block_last
  output logic                m_tvalid,
  input  logic                m_tready,
  // cost_low, cost_high, bank_b_total, tie_total
  output logic [OutDataW-1:0] m_tdata,
  output logic [OutUserW-1:0] m_tuser         // bank_select, costs_tied
);

  cmd_t    cmd;
  status_t status;

  dcbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dcbs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

@@ bench/tb_dual_codebook_bank_select.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_codebook_bank_select
// Self-checking bench for the dual codebook bank selector.
// ----------------------------------------------------------------------------
// Codepoint loads and weight elements are queued by the stimulus process and
// fed into the input stream by a driver at the falling edge. A bit-exact
// cost predictor updates at each accepted item and queues the bank choice
// expected at each block end; a monitor compares every output item with it.
// The run steps through several objective exponents, the extremes included,
// under sender-heavy, receiver-heavy and idle-free traffic.
// ----------------------------------------------------------------------------
module tb_dual_codebook_bank_select;
  import dcbs_pkg::*;

  localparam int PauseCycles   = 20;
  localparam int WatchdogLimit = 4000;
  localparam int PhaseItems    = 210;

  typedef struct {
    logic       req;
    logic       bank;
    logic [3:0] slot;
    logic [7:0] value;
    logic [15:0] weight;
    logic [15:0] mant;
    logic [7:0] expo;
    logic [7:0] idx;
    logic       last;
  } cb_item_t;

  typedef struct {
    logic         pick_b;
    logic         tied;
    logic [127:0] cost;
    logic [31:0]  b_total;
    logic [31:0]  tie_total;
  } bank_choice_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [ObjW-1:0]     cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // entry_bank, entry_slot, entry_value, weight_bits, scale_mantissa,
  // scale_exp, code_index, zero pad
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;  // req_type
  logic                s_tlast = 1'b0;  // block_last
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // cost_low, cost_high, bank_b_total, tie_total
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;          // bank_select, costs_tied

  cb_item_t     pending_items[$];
  bank_choice_t expected_choices[$];
  cb_item_t     cur_item;
  logic         in_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int obj_exp = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int loads_seen = 0;
  int elements_seen = 0;
  int blocks_checked = 0;

  logic signed [7:0] codebook[2][CbEntries];
  logic [127:0]      cost_a = '0;
  logic [127:0]      cost_b = '0;
  logic [31:0]       b_count = '0;
  logic [31:0]       tie_tally = '0;

  dual_codebook_bank_select uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #1 clk = ~clk;

  function automatic logic [127:0] quant_error_term(logic [15:0] w, logic [15:0] m,
                                                    logic signed [7:0] e,
                                                    logic signed [7:0] p);
    int                 qs;
    int                 ls;
    int                 t;
    logic [7:0]         ex;
    logic [6:0]         fr;
    longint             sig;
    longint             qbase;
    logic [127:0]       quad;
    logic signed [127:0] lin;
    ex = w[14:7];
    fr = w[6:0];
    qs = 2 * int'(e) - QBias - obj_exp;
    qbase = longint'(p) * longint'(p) * longint'(m) * longint'(m);
    quad = 128'(qbase);
    if (w[14:0] == 15'd0) begin
      if (qs < 0 || qs >= ShiftLimit) return '0;
      return quad << qs;
    end
    if (ex == ExpInfNan) return '0;
    sig = (ex == 8'd0) ? longint'(fr) : longint'(fr) + 128;
    if (w[15]) sig = -sig;
    t = (ex == 8'd0) ? SubnT : int'(ex) - NormBias;
    ls = t + int'(e) - LBias - obj_exp;
    if (ls < 0 || qs < 0 || ls >= ShiftLimit || qs >= ShiftLimit) return '0;
    lin = -2 * longint'(p) * sig * longint'(m);
    return (lin << ls) + (quad << qs);
  endfunction

  task automatic apply_item(cb_item_t it);
    bank_choice_t res;
    logic signed [7:0] pa;
    logic signed [7:0] pb;
    if (it.req == ReqEntry) begin
      codebook[it.bank][it.slot] = it.value;
      loads_seen++;
    end else begin
      elements_seen++;
      if (it.idx < CbEntries) begin
        pa = codebook[0][it.idx[CbAw-1:0]];
        pb = codebook[1][it.idx[CbAw-1:0]];
        cost_a = cost_a + quant_error_term(it.weight, it.mant, it.expo, pa);
        cost_b = cost_b + quant_error_term(it.weight, it.mant, it.expo, pb);
      end
      if (it.last) begin
        res.pick_b = $signed(cost_b) < $signed(cost_a);
        res.tied = (cost_a == cost_b);
        res.cost = res.pick_b ? cost_b : cost_a;
        if (res.pick_b) b_count++;
        if (res.tied) tie_tally++;
        res.b_total = b_count;
        res.tie_total = tie_tally;
        expected_choices.push_back(res);
        cost_a = '0;
        cost_b = '0;
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
    if (fail_count < 100)
      $display("%0t MISMATCH %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_choice();
    bank_choice_t want;
    if (expected_choices.size() == 0) begin
      report_mismatch("output item with none pending", m_tdata[127:0], '0);
      return;
    end
    want = expected_choices.pop_front();
    blocks_checked++;
    if (m_tuser[0] !== want.pick_b) report_mismatch("bank_select", m_tuser[0], want.pick_b);
    if (m_tuser[1] !== want.tied) report_mismatch("costs_tied", m_tuser[1], want.tied);
    if (m_tdata[63:0] !== want.cost[63:0])
      report_mismatch("cost_low", m_tdata[63:0], want.cost[63:0]);
    if (m_tdata[127:64] !== want.cost[127:64])
      report_mismatch("cost_high", m_tdata[127:64], want.cost[127:64]);
    if (m_tdata[159:128] !== want.b_total)
      report_mismatch("bank_b_total", m_tdata[159:128], want.b_total);
    if (m_tdata[191:160] !== want.tie_total)
      report_mismatch("tie_total", m_tdata[191:160], want.tie_total);
  endtask

  function automatic cb_item_t make_element(logic [15:0] w, logic [15:0] m, logic [7:0] e,
                                            logic [7:0] idx, logic last);
    cb_item_t it;
    it.req = ReqElement;
    it.bank = 1'($urandom);
    it.slot = 4'($urandom);
    it.value = 8'($urandom);
    it.weight = w;
    it.mant = m;
    it.expo = e;
    it.idx = idx;
    it.last = last;
    return it;
  endfunction

  function automatic cb_item_t make_entry(logic bank, logic [3:0] slot, logic [7:0] value);
    cb_item_t it;
    it = make_element(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom));
    it.req = ReqEntry;
    it.bank = bank;
    it.slot = slot;
    it.value = value;
    return it;
  endfunction

  // aim both shifts into range for the current objective exponent
  function automatic cb_item_t random_element();
    int          qs_t;
    int          ls_t;
    int          e;
    int          t;
    int          ex;
    int          pick;
    logic        neg;
    logic [15:0] w;
    pick = $urandom_range(0, 99);
    neg = 1'($urandom);
    qs_t = $urandom_range(0, ShiftLimit - 1);
    e = (qs_t + QBias + obj_exp) >>> 1;
    if (e < -128 || e > 127) e = int'($urandom_range(0, 255)) - 128;
    ls_t = $urandom_range(0, ShiftLimit - 1);
    t = ls_t - e + LBias + obj_exp;
    ex = t + NormBias;
    if (pick < 10) w = {neg, 15'd0};
    else if (pick < 13) w = {neg, ExpInfNan, 7'($urandom)};
    else if (pick < 18 || t == SubnT) w = {neg, 8'd0, 7'($urandom_range(1, 127))};
    else if (ex >= 1 && ex <= 254) w = {neg, 8'(ex), 7'($urandom)};
    else w = {neg, 8'($urandom_range(1, 254)), 7'($urandom)};
    return make_element(w, 16'($urandom), 8'(e), 8'($urandom_range(0, CbEntries - 1)),
                        $urandom_range(0, 7) == 0);
  endfunction

  task automatic queue_random_item();
    int          r;
    logic        bank;
    logic [3:0]  slot;
    logic [7:0]  value;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      bank = 1'($urandom);
      slot = 4'($urandom);
      value = 8'($urandom);
      pending_items.push_back(make_entry(bank, slot, value));
      if (r < 3) pending_items.push_back(make_entry(~bank, slot, value));
    end else if (r < 88) begin
      pending_items.push_back(random_element());
    end else begin
      pending_items.push_back(make_element(16'($urandom), 16'($urandom), 8'($urandom),
                                           8'($urandom), $urandom_range(0, 7) == 0));
    end
  endtask

  task automatic queue_directed();
    pending_items.push_back(make_entry(1'b0, 4'd0, -8'sd128));
    pending_items.push_back(make_entry(1'b1, 4'd0, 8'sd127));
    pending_items.push_back(make_entry(1'b0, 4'd15, 8'sd127));
    pending_items.push_back(make_entry(1'b1, 4'd15, -8'sd128));
    pending_items.push_back(make_entry(1'b0, 4'd1, 8'sd5));
    pending_items.push_back(make_entry(1'b1, 4'd1, 8'sd5));
    pending_items.push_back(make_element(16'h0000, 16'hFFFF, 8'd19, 8'd0, 1'b0));
    pending_items.push_back(make_element(16'h8000, 16'hFFFF, 8'd78, 8'd15, 1'b1));
    pending_items.push_back(make_element(16'h7F80, 16'h1234, 8'd40, 8'd0, 1'b1));
    pending_items.push_back(make_element(16'hFFC1, 16'hFFFF, 8'd40, 8'd15, 1'b0));
    pending_items.push_back(make_element(16'h0001, 16'h00FF, 8'd127, 8'd0, 1'b0));
    pending_items.push_back(make_element(16'h7F7F, 16'h0001, 8'd19, 8'd0, 1'b0));
    pending_items.push_back(make_element(16'hFEFF, 16'h8001, 8'd19, 8'd15, 1'b0));
    pending_items.push_back(make_element(16'h3F80, 16'h0100, 8'd40, 8'd1, 1'b1));
    pending_items.push_back(make_element(16'h4000, 16'h0000, 8'd40, 8'd0, 1'b0));
    pending_items.push_back(make_element(16'hBF80, 16'hFFFF, 8'h80, 8'd0, 1'b0));
    pending_items.push_back(make_element(16'h0080, 16'hFFFF, 8'd60, 8'd15, 1'b0));
    pending_items.push_back(make_element(16'h1234, 16'h5678, 8'd50, 8'd16, 1'b0));
    pending_items.push_back(make_element(16'hFFFF, 16'hFFFF, 8'd30, 8'd255, 1'b1));
    pending_items.push_back(make_element(16'h3C00, 16'hC000, 8'd60, 8'd0, 1'b1));
    pending_items.push_back(make_element(16'h0000, 16'h00FF, 8'd79, 8'd0, 1'b1));
  endtask

  task automatic write_objective(int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ObjW'(val);
    obj_exp = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || s_tvalid || expected_choices.size() != 0)
      @(posedge clk);
    repeat (PauseCycles) @(posedge clk);
  endtask

  always @(negedge clk) begin
    cb_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        cur_item <= nxt;
        s_tvalid <= 1'b1;
        s_tuser <= nxt.req;
        s_tlast <= nxt.last;
        s_tdata <= {3'b000, nxt.idx, nxt.expo, nxt.mant, nxt.weight, nxt.value,
                    nxt.slot, nxt.bank};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) apply_item(cur_item);
      if (m_tvalid && m_tready) check_choice();
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchdogLimit) begin
      $display("Watchdog: no item moved for %0d cycles", WatchdogLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int         ph;
    int         i;
    int         objv;
    int         obj_list[6];
    logic [7:0] va;
    obj_list = '{0, -256, 255, 0, 7, -30};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 85;
      end else if (ph < 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      objv = (ph == 3) ? int'($urandom_range(0, 80)) - 40 : obj_list[ph];
      write_objective(objv);
      if (ph == 0) begin
        queue_directed();
        // fill every slot of both banks before any random element
        for (i = 0; i < CbEntries; i++) begin
          va = 8'($urandom);
          pending_items.push_back(make_entry(1'b0, 4'(i), va));
          pending_items.push_back(make_entry(1'b1, 4'(i),
                                             ($urandom_range(0, 3) == 0) ? va : 8'($urandom)));
        end
      end
      for (i = 0; i < PhaseItems; i++) queue_random_item();
      drain();
    end
    $display("Covered %0d codebook loads and %0d elements over six objective exponents",
             loads_seen, elements_seen);
    $display("Checked %0d block results: bank B chosen %0d times, %0d ties",
             blocks_checked, b_count, tie_tally);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
